// ===== rtl/core/scb_pkg.sv =====
// shared types, constants and blend functions for the sprite coverage blend core
`timescale 1ns / 1ps

package scb_pkg;

  // queue depth between the front and the back (two entries or more)
  localparam int unsigned QueueDepth = 2;

  // colour field masks and coverage constants
  localparam logic [7:0] RedMask  = 8'hE0;
  localparam logic [7:0] GrnMask  = 8'h1C;
  localparam logic [7:0] BluMask  = 8'h03;
  localparam logic [2:0] CodeFull = 3'd7;
  localparam logic [2:0] CodeNone = 3'd0;

  // reciprocal of seven scaled by 256, exact for dividends up to 49
  localparam logic [11:0] Div7Mul = 12'd37;

  // how one pixel is to be produced
  typedef enum logic [1:0] {
    KIND_FG,
    KIND_MIX,
    KIND_PASS
  } pix_kind_e;

  // one pixel operation
  typedef struct packed {
    pix_kind_e   kind;
    logic [2:0]  code;
    logic [7:0]  bg;
  } pix_op_t;

  // one queued sprite byte, one or two pixels
  typedef struct packed {
    logic    two;
    pix_op_t first;
    pix_op_t second;
  } pix_job_t;

  // sort a coverage code into pass, foreground or blend
  function automatic pix_kind_e classify(input logic [2:0] code);
    pix_kind_e kind;
    if (code == CodeFull) begin
      kind = KIND_PASS;
    end else if (code == CodeNone) begin
      kind = KIND_FG;
    end else begin
      kind = KIND_MIX;
    end
    return kind;
  endfunction

  // truncating divide by seven for values up to 49
  function automatic logic [2:0] div7(input logic [5:0] x);
    logic [11:0] p;
    p = 12'(x) * Div7Mul;
    return p[10:8];
  endfunction

  // blend one channel of up to three bits
  function automatic logic [2:0] mix_channel(input logic [2:0] bgc, input logic [2:0] fgc,
                                             input logic [2:0] code);
    logic [5:0] sum;
    sum = 6'(bgc) * 6'(code) + 6'(fgc) * 6'(CodeFull - code);
    return div7(sum);
  endfunction

  // blend a whole RRRGGGBB pixel
  function automatic logic [7:0] blend_pixel(input logic [7:0] bg, input logic [7:0] fg,
                                             input logic [2:0] code);
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
    logic [7:0] bgm;
    logic [7:0] fgm;
    logic [7:0] bgg;
    logic [7:0] fgg;
    logic [7:0] bgb;
    logic [7:0] fgb;
    bgm = bg & RedMask;
    fgm = fg & RedMask;
    bgg = bg & GrnMask;
    fgg = fg & GrnMask;
    bgb = bg & BluMask;
    fgb = fg & BluMask;
    r = mix_channel(bgm[7:5], fgm[7:5], code);
    g = mix_channel(bgg[4:2], fgg[4:2], code);
    b = mix_channel({1'b0, bgb[1:0]}, {1'b0, fgb[1:0]}, code);
    return {r, g, b[1:0]};
  endfunction

endpackage

// ===== rtl/core/scb_front.sv =====
// front end: takes sprite bytes and turns them into classified pixel jobs
`timescale 1ns / 1ps

module scb_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          sprite_byte_i,
  input  logic [7:0]          bg_first_i,
  input  logic [7:0]          bg_second_i,
  input  logic [1:0]          pixel_count_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output scb_pkg::pix_job_t   push_job_o
);
  import scb_pkg::*;

  logic [2:0] code_first;
  logic [2:0] code_second;

  // coverage codes, unused sprite bits dropped
  assign code_first  = sprite_byte_i[7:5];
  assign code_second = sprite_byte_i[3:1];

  // a byte with no valid pixel is taken but never queued
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && (pixel_count_i != 2'd0);

  // build the job, a count of three behaves as two
  always_comb begin
    push_job_o.two         = pixel_count_i[1];
    push_job_o.first.kind  = classify(code_first);
    push_job_o.first.code  = code_first;
    push_job_o.first.bg    = bg_first_i;
    push_job_o.second.kind = classify(code_second);
    push_job_o.second.code = code_second;
    push_job_o.second.bg   = bg_second_i;
  end

endmodule

// ===== rtl/core/scb_queue.sv =====
// short job queue between front and back
`timescale 1ns / 1ps

module scb_queue #(
  parameter int unsigned Depth = scb_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  scb_pkg::pix_job_t   push_job_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output scb_pkg::pix_job_t   pop_job_o,
  output logic [$clog2(Depth+1)-1:0] fill_o
);
  import scb_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pix_job_t        store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  // handshake
  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = store_q[rd_ptr_q];
  assign fill_o       = cnt_q;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== rtl/core/scb_back.sv =====
// back end: walks the pixels of each job through the blend unit into the output register
`timescale 1ns / 1ps

module scb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          fg_color_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  scb_pkg::pix_job_t   pop_job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          pixel_out_o,
  output logic                last_of_item_o
);
  import scb_pkg::*;

  pix_job_t   job_q, job_d;
  logic       busy_q, busy_d;
  logic       second_q, second_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] pixel_q, pixel_d;
  logic       last_q, last_d;
  pix_op_t    cur_op;
  logic       cur_last;
  logic       advance;
  logic       load;
  logic [7:0] blend_px;

  // pick the pending pixel of the held job
  assign cur_op   = second_q ? job_q.second : job_q.first;
  assign cur_last = second_q || !job_q.two;
  assign advance  = busy_q && (!out_valid_q || out_ready_i);
  assign load     = !busy_q || (advance && cur_last);
  assign pop_ready_o = load;

  // blend unit
  always_comb begin
    blend_px = blend_pixel(cur_op.bg, fg_color_i, cur_op.code);
    unique case (cur_op.kind)
      KIND_PASS: pixel_d = cur_op.bg;
      KIND_MIX:  pixel_d = blend_px;
      KIND_FG:   pixel_d = fg_color_i;
      default:   pixel_d = fg_color_i;
    endcase
  end

  // job sequencing and output register
  always_comb begin
    job_d       = job_q;
    busy_d      = busy_q;
    second_d    = second_q;
    out_valid_d = out_valid_q;
    last_d      = cur_last;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      if (cur_last) begin
        busy_d = 1'b0;
      end else begin
        second_d = 1'b1;
      end
    end
    if (load && pop_valid_i) begin
      job_d    = pop_job_i;
      busy_d   = 1'b1;
      second_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (advance) begin
      pixel_q <= pixel_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = pixel_q;
  assign last_of_item_o = last_q;

endmodule

// ===== rtl/core/sprite_coverage_blend_rgb332_core.sv =====
// top level of the sprite coverage blend core for RRRGGGBB pixels
`timescale 1ns / 1ps

// Each accepted sprite byte gives one output pixel per valid pixel (one or two), and the
// core delivers one pixel per cycle while the output is not stalled; the single blend
// unit in the back end sets that rate. A byte with a pixel count of zero is taken and
// dropped. Bytes are classified on entry and wait in a short queue, so input transfers
// carry on while the output is stalled until the queue fills. Pixels pass through the
// queue, job register and output register. The foreground colour register is written
// through its own port; the user must write it only while idle, not enforced by the core.

module sprite_coverage_blend_rgb332_core #(
  parameter int unsigned QueueDepth = scb_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] fg_color_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] sprite_byte_i,
  input  logic [7:0] bg_first_i,
  input  logic [7:0] bg_second_i,
  input  logic [1:0] pixel_count_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pixel_out_o,
  output logic       last_of_item_o
);
  import scb_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [7:0]      fg_color_q;
  logic            push_valid;
  logic            push_ready;
  pix_job_t        push_job;
  logic            pop_valid;
  logic            pop_ready;
  pix_job_t        pop_job;
  logic [CntW-1:0] fill;

  // foreground colour register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fg_color_q <= fg_color_i;
    end
  end

  // front end
  scb_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sprite_byte_i (sprite_byte_i),
    .bg_first_i    (bg_first_i),
    .bg_second_i   (bg_second_i),
    .pixel_count_i (pixel_count_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_job_o    (push_job)
  );

  // job queue
  scb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job),
    .fill_o       (fill)
  );

  // back end
  scb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fg_color_i     (fg_color_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_job_i      (pop_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_out_o    (pixel_out_o),
    .last_of_item_o (last_of_item_o)
  );

  // a byte with no valid pixel never reaches the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && pixel_count_i == 2'd0) |-> !push_valid)
    else $error("zero-count byte queued");

  // queue fill never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= CntW'(QueueDepth))
    else $error("queue overfilled");

  // the second pixel of a byte follows its first without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_item_o) |=> out_valid_o)
    else $error("second pixel missing after first transfer");

endmodule

// ===== tb/tb_sprite_coverage_blend_rgb332_core.sv =====
// testbench for the sprite coverage blend core: directed table, random bytes, self-checking
`timescale 1ns / 1ps

module tb_sprite_coverage_blend_rgb332_core;

  // coverage code meanings
  localparam int CovFull = 7;
  localparam int CovNone = 0;

  // cycles to let a dropped byte clear the core before a colour write
  localparam int SettleCycles = 8;
  localparam int NumRows      = 20;
  localparam int PhaseItems   = 92;

  // one expected output pixel
  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } pix_exp_t;

  // one row of the directed table; typed rows carry their own expected pixels
  typedef struct packed {
    logic [7:0] fg;
    logic [7:0] sb;
    logic [7:0] bg0;
    logic [7:0] bg1;
    logic [1:0] cnt;
    logic       typed;
    logic [1:0] n_typed;
    logic [7:0] p0;
    logic [7:0] p1;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] fg_color_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] sprite_byte_i;
  logic [7:0] bg_first_i;
  logic [7:0] bg_second_i;
  logic [1:0] pixel_count_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] pixel_out_o;
  logic       last_of_item_o;

  pix_exp_t   pixel_q [$];
  logic [7:0] fg_model;
  int         fail_count;
  bit         calm_tail;
  dir_row_t   dir_rows [NumRows];

  sprite_coverage_blend_rgb332_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .fg_color_i     (fg_color_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sprite_byte_i  (sprite_byte_i),
    .bg_first_i     (bg_first_i),
    .bg_second_i    (bg_second_i),
    .pixel_count_i  (pixel_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_out_o    (pixel_out_o),
    .last_of_item_o (last_of_item_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // blend one RRRGGGBB pixel channel by channel, truncating
  function automatic logic [7:0] blend_rgb332(input logic [7:0] bg, input logic [7:0] fg,
                                              input logic [2:0] code);
    int w;
    int r;
    int g;
    int b;
    w = int'(code);
    if (w == CovFull) return bg;
    if (w == CovNone) return fg;
    r = (int'(bg[7:5]) * w + int'(fg[7:5]) * (CovFull - w)) / CovFull;
    g = (int'(bg[4:2]) * w + int'(fg[4:2]) * (CovFull - w)) / CovFull;
    b = (int'(bg[1:0]) * w + int'(fg[1:0]) * (CovFull - w)) / CovFull;
    return {r[2:0], g[2:0], b[1:0]};
  endfunction

  // expected pixels of one sprite byte; count three acts as two, zero gives none
  task automatic queue_pixels(input logic [7:0] sb, input logic [7:0] bg0,
                              input logic [7:0] bg1, input logic [1:0] cnt);
    bit two;
    if (cnt == 2'd0) return;
    two = (cnt >= 2'd2);
    pixel_q.push_back('{pixel: blend_rgb332(bg0, fg_model, sb[7:5]), last: !two});
    if (two) pixel_q.push_back('{pixel: blend_rgb332(bg1, fg_model, sb[3:1]), last: 1'b1});
  endtask

  // present one byte at a falling edge and hold it until the transfer
  task automatic send_item(input logic [7:0] sb, input logic [7:0] bg0,
                           input logic [7:0] bg1, input logic [1:0] cnt, input int gap);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sprite_byte_i = sb;
    bg_first_i    = bg0;
    bg_second_i   = bg1;
    pixel_count_i = cnt;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // write the foreground colour once the core has gone idle
  task automatic write_fg(input logic [7:0] value);
    in_valid_i = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    fg_color_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    fg_model = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // receiver: random stall bursts and long ready stretches, none in the tail
  initial begin : ready_gen
    int stall_left;
    int run_left;
    out_ready_i = 1'b1;
    stall_left  = 0;
    run_left    = 0;
    forever begin
      @(negedge clk_i);
      if (calm_tail) begin
        out_ready_i = 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready_i = 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready_i = 1'b0;
        stall_left  = $urandom_range(1, 17) - 1;
      end else begin
        out_ready_i = 1'b1;
        run_left    = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(0, 12);
      end
    end
  end

  // check every output transfer against the oldest expected pixel
  always @(posedge clk_i) begin
    pix_exp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel %02h last %0b", $time, pixel_out_o, last_of_item_o);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_out_o !== want.pixel) begin
          $display("%0t: pixel_out expected %02h actual %02h", $time, want.pixel,
                   pixel_out_o);
          fail_count++;
        end
        if (last_of_item_o !== want.last) begin
          $display("%0t: last_of_item expected %0b actual %0b", $time, want.last,
                   last_of_item_o);
          fail_count++;
        end
      end
    end
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin
    logic [7:0] sb;
    logic [7:0] bg0;
    logic [7:0] bg1;
    logic [1:0] cnt;
    logic [7:0] next_fg;
    int         gap_pct;
    int         pick;
    fail_count    = 0;
    calm_tail     = 1'b0;
    fg_model      = 8'h00;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    fg_color_i    = 8'h00;
    in_valid_i    = 1'b0;
    sprite_byte_i = 8'h00;
    bg_first_i    = 8'h00;
    bg_second_i   = 8'h00;
    pixel_count_i = 2'd0;

    // fg, byte, bg first, bg second, count, typed, typed pixels, pixel a, pixel b
    dir_rows = '{
      '{8'h00, 8'hE0, 8'h5A, 8'hA5, 2'd2, 1'b1, 2'd2, 8'h5A, 8'h00},
      '{8'h00, 8'h00, 8'hFF, 8'hFF, 2'd2, 1'b1, 2'd2, 8'h00, 8'h00},
      '{8'h00, 8'hFF, 8'h12, 8'h34, 2'd2, 1'b1, 2'd2, 8'h12, 8'h34},
      '{8'h00, 8'hEE, 8'h9C, 8'h77, 2'd1, 1'b1, 2'd1, 8'h9C, 8'h00},
      '{8'h00, 8'h00, 8'hFF, 8'hFF, 2'd0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'h00, 8'h6A, 8'hFF, 8'h80, 2'd3, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'h00, 8'h24, 8'hFF, 8'hFF, 2'd2, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hFF, 8'h00, 8'h00, 8'h00, 2'd2, 1'b1, 2'd2, 8'hFF, 8'hFF},
      '{8'hFF, 8'hEE, 8'h00, 8'h00, 2'd2, 1'b1, 2'd2, 8'h00, 8'h00},
      '{8'hFF, 8'h11, 8'h3C, 8'hC3, 2'd3, 1'b1, 2'd2, 8'hFF, 8'hFF},
      '{8'hFF, 8'h48, 8'h00, 8'h00, 2'd2, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hFF, 8'h9E, 8'h49, 8'hB6, 2'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hFF, 8'hC6, 8'h00, 8'hFF, 2'd2, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hE0, 8'h8A, 8'h1F, 8'h03, 2'd2, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'hE0, 8'h2C, 8'hFF, 8'h00, 2'd2, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'h1C, 8'hA4, 8'hE3, 8'hE0, 2'd2, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'h1C, 8'h50, 8'h00, 8'hFF, 2'd1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'h03, 8'h7E, 8'h03, 8'hFC, 2'd2, 1'b0, 2'd0, 8'h00, 8'h00},
      '{8'h03, 8'h00, 8'hFF, 8'hFF, 2'd0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'h6D, 8'h32, 8'h92, 8'h92, 2'd2, 1'b0, 2'd0, 8'h00, 8'h00}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table; the first rows rely on the colour after reset
    for (int i = 0; i < NumRows; i++) begin
      if (dir_rows[i].fg != fg_model) write_fg(dir_rows[i].fg);
      if (dir_rows[i].typed) begin
        for (int n = 0; n < int'(dir_rows[i].n_typed); n++) begin
          pixel_q.push_back('{pixel: (n == 0) ? dir_rows[i].p0 : dir_rows[i].p1,
                              last: (n == int'(dir_rows[i].n_typed) - 1)});
        end
      end else begin
        queue_pixels(dir_rows[i].sb, dir_rows[i].bg0, dir_rows[i].bg1, dir_rows[i].cnt);
      end
      send_item(dir_rows[i].sb, dir_rows[i].bg0, dir_rows[i].bg1, dir_rows[i].cnt,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0);
    end

    // random phases, each under its own foreground colour
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1:       next_fg = 8'hFF;
        2:       next_fg = 8'h00;
        default: next_fg = 8'($urandom);
      endcase
      write_fg(next_fg);
      gap_pct   = (ph == 0 || ph == 5) ? 0 : ((ph % 2 == 1) ? 25 : 50);
      calm_tail = (ph == 5);
      for (int k = 0; k < PhaseItems; k++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) cnt = 2'd0;
        else if (pick < 4) cnt = 2'd1;
        else if (pick < 6) cnt = 2'd3;
        else cnt = 2'd2;
        sb  = 8'($urandom);
        bg0 = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                          : 8'($urandom);
        bg1 = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                          : 8'($urandom);
        queue_pixels(sb, bg0, bg1, cnt);
        send_item(sb, bg0, bg1, cnt,
                  ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 17) : 0);
      end
    end

    // drain the remaining pixels, then let the core settle
    in_valid_i = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sprite_coverage_blend_rgb332_core.f =====
rtl/core/scb_pkg.sv
rtl/core/scb_front.sv
rtl/core/scb_queue.sv
rtl/core/scb_back.sv
rtl/core/sprite_coverage_blend_rgb332_core.sv
tb/tb_sprite_coverage_blend_rgb332_core.sv
